### design/dq_pkg.sv
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [31:0] front_value;
        logic [31:0] rear_value;
        logic [4:0]  element_count;
        logic        is_empty;
        logic        rejected;
    } out_word_t;

    // per-cell move controls
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load;
    } cell_ctrl_t;

endpackage

### design/dq_cell.sv
module dq_cell (
    input  logic                          aclk,
    input  dq_pkg::cell_ctrl_t            ctrl,
    input  logic [dq_pkg::DATA_WIDTH-1:0] left_data,
    input  logic [dq_pkg::DATA_WIDTH-1:0] right_data,
    input  logic [dq_pkg::DATA_WIDTH-1:0] load_data,
    output logic [dq_pkg::DATA_WIDTH-1:0] data
);

    logic [dq_pkg::DATA_WIDTH-1:0] data_reg;
    logic [dq_pkg::DATA_WIDTH-1:0] data_next;

    // take from a neighbour, from the new word, or hold
    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_right) begin
            data_next = left_data;
        end else if (ctrl.shift_left) begin
            data_next = right_data;
        end else if (ctrl.load) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### design/double_ended_queue.sv
// Bounded double-ended queue of dq_pkg::DEPTH elements held in a row of cells, cell 0
// always holding the front. An insert at the front shifts every cell one place back,
// a removal from the front shifts every cell one place forward, and an insert at the
// back loads the cell just past the rear. Each input word gives exactly one result word
// with the front and rear after the operation, the element count, an empty flag and a
// rejected flag (insert when full, removal when empty). The cell row updates when a
// word is accepted; the result register then reads the front cell and the rear cell
// once it is free to load, so a new word is taken only after the last one's result
// is loaded. The result register lets the next word be accepted while a result waits.
module double_ended_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dq_pkg::in_word_t  s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output dq_pkg::out_word_t m_word
);

    logic [dq_pkg::CNT_W-1:0]      count_reg;
    logic [dq_pkg::CNT_W-1:0]      count_next;
    logic                          pending_reg;
    logic                          pending_next;
    logic                          reject_reg;
    logic                          reject_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    dq_pkg::out_word_t             out_reg;
    dq_pkg::out_word_t             out_next;

    logic                          accept;
    logic                          is_full;
    logic                          is_zero;
    logic                          load_out;
    logic [dq_pkg::IDX_W-1:0]      rear_idx;
    dq_pkg::cell_ctrl_t            cell_ctrl [dq_pkg::DEPTH];
    logic [dq_pkg::DATA_WIDTH-1:0] cell_data [dq_pkg::DEPTH];

    assign accept  = s_valid && s_ready;
    assign is_full = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign is_zero = (count_reg == '0);
    assign s_ready = !pending_reg;

    // per-cell controls from the operation and the count
    always_comb begin
        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
            cell_ctrl[i].shift_right = accept && !is_full
                && (s_word.operation == dq_pkg::OP_PUSH_FRONT);
            cell_ctrl[i].shift_left  = accept && !is_zero
                && (s_word.operation == dq_pkg::OP_POP_FRONT);
            cell_ctrl[i].load        = accept && !is_full
                && (s_word.operation == dq_pkg::OP_PUSH_BACK)
                && (count_reg == dq_pkg::CNT_W'(i));
        end
    end

    // row of cells, each fed by its neighbours
    for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
        logic [dq_pkg::DATA_WIDTH-1:0] left_d;
        logic [dq_pkg::DATA_WIDTH-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = s_word.value;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == dq_pkg::DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        dq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[g]),
            .left_data  (left_d),
            .right_data (right_d),
            .load_data  (s_word.value),
            .data       (cell_data[g])
        );
    end

    // count update and rejection
    always_comb begin
        count_next  = count_reg;
        reject_next = reject_reg;
        if (accept) begin
            reject_next = 1'b0;
            case (s_word.operation) inside
                dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
                    if (is_full) begin
                        reject_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default: begin
                    if (is_zero) begin
                        reject_next = 1'b1;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    // result register reads front and rear cells
    assign load_out = pending_reg && (!m_valid_reg || m_ready);
    assign rear_idx = dq_pkg::IDX_W'(count_reg - 1'b1);

    always_comb begin
        pending_next = pending_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            pending_next = 1'b1;
        end else if (load_out) begin
            pending_next  = 1'b0;
            m_valid_next  = 1'b1;
            out_next.front_value   = is_zero ? '0 : 32'(cell_data[0]);
            out_next.rear_value    = is_zero ? '0 : 32'(cell_data[rear_idx]);
            out_next.element_count = 5'(count_reg);
            out_next.is_empty      = is_zero;
            out_next.rejected      = reject_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        reject_reg <= reject_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("element count beyond depth");

    a_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> pending_reg)
        else $error("accepted word not marked pending");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.is_empty == (out_reg.element_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_full && (s_word.operation == dq_pkg::OP_PUSH_FRONT
            || s_word.operation == dq_pkg::OP_PUSH_BACK))
        |=> (count_reg == $past(count_reg)) && reject_reg)
        else $error("insert into full queue not rejected");

endmodule

### bench/double_ended_queue_test.sv
module double_ended_queue_test;

    localparam int          RANDOM_WORDS = 1725;
    localparam int          BLOCK_WORDS  = 25;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          PRINT_LIMIT  = 30;

    typedef enum int {FILLING, DRAINING, BALANCED, SCATTERED} mix_t;

    typedef struct {
        dq_pkg::in_word_t  word;
        bit                typed;
        dq_pkg::out_word_t want;
    } row_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    dq_pkg::in_word_t  s_word  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    dq_pkg::out_word_t m_word;

    // shadow copy of the deque
    logic [dq_pkg::DATA_WIDTH-1:0] shadow_cells [dq_pkg::DEPTH];
    logic [dq_pkg::IDX_W-1:0]      shadow_head;
    logic [dq_pkg::IDX_W-1:0]      shadow_tail;
    logic [dq_pkg::CNT_W-1:0]      shadow_count;

    dq_pkg::out_word_t pending_views [$];
    row_t              stimulus_rows [$];
    dq_pkg::out_word_t oldest_view;
    bit          steady       = 1'b0;
    int          fault_count  = 0;
    int          word_count   = 0;
    int          result_count = 0;
    int          full_refusals  = 0;
    int          empty_refusals = 0;
    int unsigned cycle_count  = 0;

    double_ended_queue u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // expected front, rear and count after one operation
    function automatic dq_pkg::out_word_t apply_op(dq_pkg::in_word_t w);
        dq_pkg::out_word_t r;
        r = '0;
        case (w.operation)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
                if (shadow_count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
                    r.rejected = 1'b1;
                end else if (shadow_count == '0) begin
                    shadow_cells[shadow_head] = w.value;
                    shadow_tail  = shadow_head;
                    shadow_count = dq_pkg::CNT_W'(1);
                end else if (w.operation == dq_pkg::OP_PUSH_FRONT) begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_cells[shadow_head] = w.value;
                    shadow_count = shadow_count + 1'b1;
                end else begin
                    shadow_tail = shadow_tail + 1'b1;
                    shadow_cells[shadow_tail] = w.value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            default: begin
                if (shadow_count == '0) begin
                    r.rejected = 1'b1;
                end else begin
                    // a single element leaves both indices where they are
                    if (shadow_count > dq_pkg::CNT_W'(1)) begin
                        if (w.operation == dq_pkg::OP_POP_FRONT)
                            shadow_head = shadow_head + 1'b1;
                        else
                            shadow_tail = shadow_tail - 1'b1;
                    end
                    shadow_count = shadow_count - 1'b1;
                end
            end
        endcase
        if (shadow_count != '0) begin
            r.front_value = shadow_cells[shadow_head];
            r.rear_value  = shadow_cells[shadow_tail];
        end
        r.element_count = shadow_count;
        r.is_empty      = (shadow_count == '0);
        return r;
    endfunction

    function automatic dq_pkg::out_word_t view(logic [31:0] f, logic [31:0] r,
                                               logic [4:0] n, logic rej);
        dq_pkg::out_word_t v;
        v.front_value   = f;
        v.rear_value    = r;
        v.element_count = n;
        v.is_empty      = (n == '0);
        v.rejected      = rej;
        return v;
    endfunction

    task automatic add_row(dq_pkg::op_t op, logic [31:0] value, bit typed,
                           dq_pkg::out_word_t want);
        row_t row;
        row.word.operation = op;
        row.word.value     = value;
        row.typed          = typed;
        row.want           = want;
        stimulus_rows.push_back(row);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (fault_count < PRINT_LIMIT)
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, result_count, got, want);
        fault_count++;
    endtask

    // present one word after a gap and log its expectation on acceptance
    task automatic send_word(dq_pkg::in_word_t w, int gap, bit typed,
                             dq_pkg::out_word_t typed_view);
        dq_pkg::out_word_t predicted;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_op(w);
        if (predicted.rejected) begin
            if (predicted.element_count == '0) empty_refusals++;
            else full_refusals++;
        end
        pending_views.push_back(typed ? typed_view : predicted);
        word_count++;
    endtask

    // hold the sender off until every result is back
    task automatic drain_wait();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_views.size() != 0) @(negedge aclk);
    endtask

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_views.size() == 0) begin
                report_mismatch("word with nothing pending", m_word.front_value, '0);
            end else begin
                oldest_view = pending_views.pop_front();
                if (m_word.front_value !== oldest_view.front_value)
                    report_mismatch("front_value", m_word.front_value,
                                    oldest_view.front_value);
                if (m_word.rear_value !== oldest_view.rear_value)
                    report_mismatch("rear_value", m_word.rear_value, oldest_view.rear_value);
                if (m_word.element_count !== oldest_view.element_count)
                    report_mismatch("element_count", 32'(m_word.element_count),
                                    32'(oldest_view.element_count));
                if (m_word.is_empty !== oldest_view.is_empty)
                    report_mismatch("is_empty", 32'(m_word.is_empty), 32'(oldest_view.is_empty));
                if (m_word.rejected !== oldest_view.rejected)
                    report_mismatch("rejected", 32'(m_word.rejected), 32'(oldest_view.rejected));
            end
            result_count++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // stimulus
    initial begin
        dq_pkg::in_word_t w;
        mix_t             mix;
        bit               grow;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_count = '0;

        // directed rows: empty removals, extremes, fill to full, refusals when full
        add_row(dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1, view(32'h0, 32'h0, 5'd0, 1'b1));
        add_row(dq_pkg::OP_POP_BACK,   32'h1234_5678, 1, view(32'h0, 32'h0, 5'd0, 1'b1));
        add_row(dq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1,
                view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0));
        add_row(dq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1,
                view(32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0));
        add_row(dq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1, view(32'h0, 32'h0, 5'd1, 1'b0));
        add_row(dq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1, view(32'h0, 32'h0, 5'd0, 1'b0));
        add_row(dq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 1, view(32'h1, 32'h1, 5'd1, 1'b0));
        add_row(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'h5A5A_5A5A, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFE, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'h0F0F_0F0F, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'hF0F0_F0F0, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'h0000_FFFF, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_0000, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'h3333_3333, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'hCCCC_CCCC, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'h5555_5555, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'h0000_0002, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'hDEAD_0001, 0, '0);
        add_row(dq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 0, '0);
        add_row(dq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 0, '0);
        add_row(dq_pkg::OP_POP_FRONT,  32'h0000_0000, 0, '0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stimulus_rows[i])
            send_word(stimulus_rows[i].word, $urandom_range(0, 3),
                      stimulus_rows[i].typed, stimulus_rows[i].want);
        drain_wait();

        // random blocks, each leaning towards filling, draining or neither
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % BLOCK_WORDS == 0) begin
                mix    = mix_t'($urandom_range(0, 3));
                steady = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_WORDS / 2) drain_wait();
            case (mix)
                FILLING:  grow = ($urandom_range(0, 3) != 0);
                DRAINING: grow = ($urandom_range(0, 3) == 0);
                default:  grow = $urandom_range(0, 1);
            endcase
            if (mix == SCATTERED)
                w.operation = dq_pkg::op_t'($urandom_range(0, 3));
            else if (grow)
                w.operation = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK
                                                   : dq_pkg::OP_PUSH_FRONT;
            else
                w.operation = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK
                                                   : dq_pkg::OP_POP_FRONT;
            case ($urandom_range(0, 7))
                0:       w.value = 32'h0000_0000;
                1:       w.value = 32'hFFFF_FFFF;
                default: w.value = $urandom;
            endcase
            send_word(w, steady ? 0 : $urandom_range(0, 3), 1'b0, '0);
        end

        drain_wait();
        repeat (8) @(posedge aclk);

        $display("covered %0d words and %0d results", word_count, result_count);
        $display("refused %0d inserts on full and %0d removals on empty",
                 full_refusals, empty_refusals);
        if (fault_count == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule

### double_ended_queue.f
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue.sv
bench/double_ended_queue_test.sv
